// File: rtl/core/bge_pkg.sv
// Shared types, codes and character helpers of the grammar executor.
package bge_pkg;

    // Commands carried by an input transfer
    localparam logic [1:0] CMD_WR_GRAMMAR = 2'd0;
    localparam logic [1:0] CMD_WR_INPUT   = 2'd1;
    localparam logic [1:0] CMD_RUN        = 2'd2;
    localparam logic [1:0] CMD_RD_OUTPUT  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE_FLAGS = 2'd0;
    localparam logic [1:0] REG_GRAM_LEN   = 2'd1;
    localparam logic [1:0] REG_INPUT_LEN  = 2'd2;

    // Run status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNPARSABLE = 3'd1;
    localparam logic [2:0] ST_CALL_OVF   = 3'd2;
    localparam logic [2:0] ST_UNDO_OVF   = 3'd3;
    localparam logic [2:0] ST_OUT_LONG   = 3'd4;
    localparam logic [2:0] ST_MALFORMED  = 3'd5;

    // Interpreter modes
    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_PARSE  = 2'd1;
    localparam logic [1:0] MODE_BACK   = 2'd2;

    // Mode flag bit positions
    localparam int F_SKIP_DIGIT = 1;
    localparam int F_SKIP_LOWER = 2;
    localparam int F_SKIP_UPPER = 3;
    localparam int F_SKIP_ANY   = 4;
    localparam int F_PASS_DIGIT = 5;
    localparam int F_PASS_LOWER = 6;
    localparam int F_PASS_UPPER = 7;
    localparam int F_PASS_ANY   = 8;

    // Grammar start position after the zero-th rule prefix
    localparam int PREFIX_LEN = 5;

    // Characters of the grammar notation
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_UL    = 8'h4C;
    localparam logic [7:0] CH_LL    = 8'h6C;

    // Grammar pointer operations
    localparam logic [3:0] GP_HOLD   = 4'd0;
    localparam logic [3:0] GP_INC1   = 4'd1;
    localparam logic [3:0] GP_INC3   = 4'd2;
    localparam logic [3:0] GP_DEC1   = 4'd3;
    localparam logic [3:0] GP_DEC3   = 4'd4;
    localparam logic [3:0] GP_PREFIX = 4'd5;
    localparam logic [3:0] GP_TOP_P1 = 4'd6;
    localparam logic [3:0] GP_TOP_M1 = 4'd7;
    localparam logic [3:0] GP_UTOP   = 4'd8;

    // Counter operations (input pointer, output length)
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_ZERO = 2'd3;

    // Stack operations
    localparam logic [1:0] STK_HOLD = 2'd0;
    localparam logic [1:0] STK_PUSH = 2'd1;
    localparam logic [1:0] STK_POP  = 2'd2;
    localparam logic [1:0] STK_INIT = 2'd3;

    // Grammar read address selects
    localparam logic [1:0] GS_GP  = 2'd0;
    localparam logic [1:0] GS_GP1 = 2'd1;
    localparam logic [1:0] GS_GP2 = 2'd2;
    localparam logic [1:0] GS_TOP = 2'd3;

    typedef struct packed {
        logic [3:0] gp_op;
        logic [1:0] ip_op;
        logic [1:0] ol_op;
        logic [1:0] nc_op;
        logic [1:0] nu_op;
        logic [1:0] gsel;
        logic       emit;
        logic       emit_lit;
        logic       cap_c0;
        logic       cap_fetch;
        logic       cap_c1;
        logic       cap_c2;
        logic       wr_grammar;
        logic       wr_input;
        logic       rd_output;
        logic       fin;
        logic       fin_run;
        logic       fin_ok;
    } t_dp_cmd;

    typedef struct packed {
        logic [7:0] gdat;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] ch;
        logic [8:0] mflags;
        logic       nc_zero;
        logic       nc_le1;
        logic       nc_full;
        logic       nu_zero;
        logic       nu_full;
        logic       ol_full;
        logic       ol_nz;
        logic       any_left;
        logic       gp_end;
    } t_dp_stat;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_NL);
    endfunction

endpackage

// File: rtl/core/bge_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bge_dp.sv
// Datapath: memories, stacks, run pointers and configuration registers.
module bge_dp #(
    parameter int MEM_DEPTH  = 4096,
    parameter int CALL_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bge_pkg::t_dp_cmd   i_cmd,
    output bge_pkg::t_dp_stat  o_stat,
    input  logic [11:0]        i_index,
    input  logic [7:0]         i_byte,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    output logic [12:0]        o_out_length,
    output logic [7:0]         o_byte_out
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int CW = $clog2(CALL_DEPTH);
    localparam int PW = ((AW > 13) ? AW : 13) + 2;
    localparam logic [PW-1:0] MEM_LIM  = PW'(MEM_DEPTH);
    localparam logic [CW:0]   CALL_LIM = (CW+1)'(CALL_DEPTH);
    localparam logic [AW:0]   UNDO_LIM = (AW+1)'(MEM_DEPTH);

    logic [8:0]    r_mflags;
    logic [12:0]   r_glen;
    logic [11:0]   r_ilen;
    logic [PW-1:0] r_gp, n_gp, r_ip, n_ip, r_top, r_utop;
    logic [AW:0]   r_olen, n_olen, r_nundo, n_nundo, r_last_len;
    logic [CW:0]   r_ncall, n_ncall, nc_m1;
    logic [AW:0]   nu_m1;
    logic [7:0]    r_c0, r_c1, r_c2, r_ch, r_byte;
    logic          r_gvld, r_ivld, r_rvld;
    logic [PW-1:0] g_q;
    logic [7:0]    g_rdata, i_rdata, o_rdata, gdat, idat;
    logic [PW-1:0] cs_rdata, ud_rdata, cs_wdata;
    logic [CW-1:0] cs_waddr;
    logic          cs_we, g_we, i_we, ld_ok;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mflags <= '0;
            r_glen   <= 13'(bge_pkg::PREFIX_LEN);
            r_ilen   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bge_pkg::REG_MODE_FLAGS: r_mflags <= i_cfg_data[8:0];
                bge_pkg::REG_GRAM_LEN:   r_glen   <= i_cfg_data;
                bge_pkg::REG_INPUT_LEN:  r_ilen   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Grammar read address select
    always_comb begin
        unique case (i_cmd.gsel)
            bge_pkg::GS_GP:  g_q = r_gp;
            bge_pkg::GS_GP1: g_q = r_gp + PW'(1);
            bge_pkg::GS_GP2: g_q = r_gp + PW'(2);
            bge_pkg::GS_TOP: g_q = r_top;
            default:         g_q = r_gp;
        endcase
    end

    assign ld_ok = (32'(i_index) < MEM_DEPTH);
    assign g_we  = i_cmd.wr_grammar && ld_ok;
    assign i_we  = i_cmd.wr_input && ld_ok;

    bge_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_gram (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(AW'(i_index)), .i_wdata(i_byte),
        .i_raddr(g_q[AW-1:0]), .o_rdata(g_rdata)
    );

    bge_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_input (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(AW'(i_index)), .i_wdata(i_byte),
        .i_raddr(r_ip[AW-1:0]), .o_rdata(i_rdata)
    );

    bge_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_output (
        .i_clk(i_clk), .i_we(i_cmd.emit), .i_waddr(r_olen[AW-1:0]),
        .i_wdata(i_cmd.emit_lit ? r_c1 : r_ch),
        .i_raddr(AW'(i_index)), .o_rdata(o_rdata)
    );

    // Call stack: push the current position, or seed the goal call
    assign nc_m1    = r_ncall - (CW+1)'(1);
    assign cs_we    = (i_cmd.nc_op == bge_pkg::STK_PUSH) || (i_cmd.nc_op == bge_pkg::STK_INIT);
    assign cs_waddr = (i_cmd.nc_op == bge_pkg::STK_INIT) ? '0 : r_ncall[CW-1:0];
    assign cs_wdata = (i_cmd.nc_op == bge_pkg::STK_INIT) ? PW'(1) : r_gp;

    bge_ram #(.WIDTH(PW), .DEPTH(CALL_DEPTH)) u_call (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_waddr), .i_wdata(cs_wdata),
        .i_raddr(nc_m1[CW-1:0]), .o_rdata(cs_rdata)
    );

    // Undo stack holds the position before a completed rule's semicolon
    assign nu_m1 = r_nundo - (AW+1)'(1);

    bge_ram #(.WIDTH(PW), .DEPTH(MEM_DEPTH)) u_undo (
        .i_clk(i_clk), .i_we(i_cmd.nu_op == bge_pkg::STK_PUSH),
        .i_waddr(r_nundo[AW-1:0]), .i_wdata(r_gp - PW'(1)),
        .i_raddr(nu_m1[AW-1:0]), .o_rdata(ud_rdata)
    );

    // Out-of-range reads return zero
    assign gdat = r_gvld ? g_rdata : 8'h00;
    assign idat = r_ivld ? i_rdata : 8'h00;

    // Next pointer values
    always_comb begin
        unique case (i_cmd.gp_op)
            bge_pkg::GP_INC1:   n_gp = r_gp + PW'(1);
            bge_pkg::GP_INC3:   n_gp = r_gp + PW'(3);
            bge_pkg::GP_DEC1:   n_gp = r_gp - PW'(1);
            bge_pkg::GP_DEC3:   n_gp = r_gp - PW'(3);
            bge_pkg::GP_PREFIX: n_gp = PW'(bge_pkg::PREFIX_LEN);
            bge_pkg::GP_TOP_P1: n_gp = r_top + PW'(1);
            bge_pkg::GP_TOP_M1: n_gp = r_top - PW'(1);
            bge_pkg::GP_UTOP:   n_gp = r_utop;
            default:            n_gp = r_gp;
        endcase
        unique case (i_cmd.ip_op)
            bge_pkg::CNT_HOLD: n_ip = r_ip;
            bge_pkg::CNT_INC:  n_ip = r_ip + PW'(1);
            bge_pkg::CNT_DEC:  n_ip = r_ip - PW'(1);
            bge_pkg::CNT_ZERO: n_ip = '0;
        endcase
        unique case (i_cmd.ol_op)
            bge_pkg::CNT_HOLD: n_olen = r_olen;
            bge_pkg::CNT_INC:  n_olen = r_olen + (AW+1)'(1);
            bge_pkg::CNT_DEC:  n_olen = r_olen - (AW+1)'(1);
            bge_pkg::CNT_ZERO: n_olen = '0;
        endcase
        unique case (i_cmd.nc_op)
            bge_pkg::STK_HOLD: n_ncall = r_ncall;
            bge_pkg::STK_PUSH: n_ncall = r_ncall + (CW+1)'(1);
            bge_pkg::STK_POP:  n_ncall = nc_m1;
            bge_pkg::STK_INIT: n_ncall = (CW+1)'(1);
        endcase
        unique case (i_cmd.nu_op)
            bge_pkg::STK_HOLD: n_nundo = r_nundo;
            bge_pkg::STK_PUSH: n_nundo = r_nundo + (AW+1)'(1);
            bge_pkg::STK_POP:  n_nundo = nu_m1;
            bge_pkg::STK_INIT: n_nundo = '0;
        endcase
    end

    // Run pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp    <= '0;
            r_ip    <= '0;
            r_olen  <= '0;
            r_ncall <= '0;
            r_nundo <= '0;
        end else begin
            r_gp    <= n_gp;
            r_ip    <= n_ip;
            r_olen  <= n_olen;
            r_ncall <= n_ncall;
            r_nundo <= n_nundo;
        end
    end

    // Fetched characters and read data
    always_ff @(posedge i_clk) begin
        r_gvld  <= !g_q[PW-1] && (g_q < PW'(r_glen)) && (g_q < MEM_LIM);
        r_ivld  <= !r_ip[PW-1] && (r_ip < PW'(r_ilen)) && (r_ip < MEM_LIM);
        if (i_cmd.cap_c0) begin
            r_c0 <= gdat;
        end
        if (i_cmd.cap_fetch) begin
            r_ch   <= idat;
            r_top  <= cs_rdata;
            r_utop <= ud_rdata;
        end
        if (i_cmd.cap_c1) begin
            r_c1 <= gdat;
        end
        if (i_cmd.cap_c2) begin
            r_c2 <= gdat;
        end
        if (i_cmd.fin) begin
            r_byte <= (i_cmd.rd_output || !r_rvld) ? 8'h00 : o_rdata;
        end
    end

    // Result length of the last run; read-valid flag lives for one command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_len <= '0;
            r_rvld     <= 1'b0;
        end else begin
            if (i_cmd.rd_output) begin
                r_rvld <= (32'(i_index) < 32'(r_last_len)) && ld_ok;
            end else if (i_cmd.fin) begin
                r_rvld <= 1'b0;
            end
            if (i_cmd.fin && i_cmd.fin_run) begin
                r_last_len <= i_cmd.fin_ok ? r_olen : '0;
            end
        end
    end

    assign o_out_length = 13'(r_last_len);
    assign o_byte_out   = r_byte;

    // Status to the controller
    always_comb begin
        o_stat.gdat     = gdat;
        o_stat.c0       = r_c0;
        o_stat.c1       = r_c1;
        o_stat.c2       = r_c2;
        o_stat.ch       = r_ch;
        o_stat.mflags   = r_mflags;
        o_stat.nc_zero  = (r_ncall == '0);
        o_stat.nc_le1   = (r_ncall <= (CW+1)'(1));
        o_stat.nc_full  = (r_ncall >= CALL_LIM);
        o_stat.nu_zero  = (r_nundo == '0);
        o_stat.nu_full  = (r_nundo >= UNDO_LIM);
        o_stat.ol_full  = (r_olen >= UNDO_LIM);
        o_stat.ol_nz    = (r_olen != '0);
        o_stat.any_left = !r_ip[PW-1] && (r_ip < PW'(r_ilen));
        o_stat.gp_end   = (r_gp == PW'(r_glen));
    end

endmodule

// File: rtl/core/bge_ctrl.sv
// Controller: command sequencing and SEARCH/PARSE/BACK step decisions.
module bge_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  logic [1:0]         i_cmd,
    output logic               o_s_ready,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output logic [2:0]         o_status,
    input  bge_pkg::t_dp_stat  i_st,
    output bge_pkg::t_dp_cmd   o_dp
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FIN  = 4'd1;
    localparam logic [3:0] S_INIT = 4'd2;
    localparam logic [3:0] S_DB0  = 4'd3;
    localparam logic [3:0] S_DB1  = 4'd4;
    localparam logic [3:0] S_F0   = 4'd5;
    localparam logic [3:0] S_F1   = 4'd6;
    localparam logic [3:0] S_F2   = 4'd7;
    localparam logic [3:0] S_F3   = 4'd8;
    localparam logic [3:0] S_EX   = 4'd9;
    localparam logic [3:0] S_SA   = 4'd10;
    localparam logic [3:0] S_SB   = 4'd11;
    localparam logic [3:0] S_SE   = 4'd12;

    logic [3:0] r_state, n_state, r_ret, n_ret;
    logic [1:0] r_mode, n_mode, r_kind, n_kind;
    logic [2:0] r_run_st, n_run_st, r_last_st, n_last_st;
    logic       r_ovalid, n_ovalid;
    logic       accept, done;
    logic [2:0] dst;
    logic       take_en, take_ok, take_pass, do_call, do_uncall, cls, cls_on;
    logic [8:0] mf;
    logic [7:0] c;

    assign o_s_ready = (r_state == S_IDLE) && !r_ovalid;
    assign accept    = i_s_valid && o_s_ready;
    assign mf        = i_st.mflags;
    assign c         = i_st.c0;

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_mode    = r_mode;
        n_kind    = r_kind;
        n_run_st  = r_run_st;
        n_last_st = r_last_st;
        n_ovalid  = r_ovalid && !i_m_ready;
        o_dp      = '0;
        done      = 1'b0;
        dst       = bge_pkg::ST_OK;
        take_en   = 1'b0;
        take_ok   = 1'b0;
        take_pass = 1'b0;
        do_call   = 1'b0;
        do_uncall = 1'b0;
        cls       = 1'b0;
        cls_on    = 1'b0;

        unique case (r_state)
            // Take a command; loads and reads finish in the next cycle
            S_IDLE: begin
                if (accept) begin
                    n_kind = i_cmd;
                    unique case (i_cmd)
                        bge_pkg::CMD_WR_GRAMMAR: begin
                            o_dp.wr_grammar = 1'b1;
                            n_state = S_FIN;
                        end
                        bge_pkg::CMD_WR_INPUT: begin
                            o_dp.wr_input = 1'b1;
                            n_state = S_FIN;
                        end
                        bge_pkg::CMD_RUN: n_state = S_INIT;
                        bge_pkg::CMD_RD_OUTPUT: begin
                            o_dp.rd_output = 1'b1;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // Latch the result and present it
            S_FIN: begin
                o_dp.fin     = 1'b1;
                o_dp.fin_run = (r_kind == bge_pkg::CMD_RUN);
                o_dp.fin_ok  = (r_run_st == bge_pkg::ST_OK);
                if (r_kind == bge_pkg::CMD_RUN) begin
                    n_last_st = r_run_st;
                end
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end

            // Seed the goal call and clear the pointers
            S_INIT: begin
                o_dp.gp_op = bge_pkg::GP_PREFIX;
                o_dp.ip_op = bge_pkg::CNT_ZERO;
                o_dp.ol_op = bge_pkg::CNT_ZERO;
                o_dp.nc_op = bge_pkg::STK_INIT;
                o_dp.nu_op = bge_pkg::STK_INIT;
                n_mode  = bge_pkg::MODE_SEARCH;
                n_ret   = S_F0;
                n_state = S_DB0;
            end

            // Skip blanks; leave the first other character in c0
            S_DB0: begin
                o_dp.gsel = bge_pkg::GS_GP;
                n_state   = S_DB1;
            end
            S_DB1: begin
                o_dp.cap_c0 = 1'b1;
                if (bge_pkg::is_blank(i_st.gdat)) begin
                    o_dp.gp_op = bge_pkg::GP_INC1;
                    n_state    = S_DB0;
                end else begin
                    n_state = r_ret;
                end
            end

            // Fetch the item, its two followers, the input char and stack tops
            S_F0: begin
                o_dp.gsel = bge_pkg::GS_GP;
                n_state   = S_F1;
            end
            S_F1: begin
                o_dp.cap_c0    = 1'b1;
                o_dp.cap_fetch = 1'b1;
                o_dp.gsel      = bge_pkg::GS_GP1;
                n_state        = S_F2;
            end
            S_F2: begin
                o_dp.cap_c1 = 1'b1;
                o_dp.gsel   = bge_pkg::GS_GP2;
                n_state     = S_F3;
            end
            S_F3: begin
                o_dp.cap_c2 = 1'b1;
                n_state     = S_EX;
            end

            // Execute one step of the current mode
            S_EX: begin
                n_state = S_F0;
                if (r_mode == bge_pkg::MODE_PARSE) begin
                    priority case (c)
                        bge_pkg::CH_UA: begin
                            cls = mf[bge_pkg::F_PASS_ANY];
                            take_ok = i_st.any_left;
                            take_pass = 1'b1;
                        end
                        bge_pkg::CH_LA: begin
                            cls = mf[bge_pkg::F_SKIP_ANY];
                            take_ok = i_st.any_left;
                        end
                        bge_pkg::CH_UD: begin
                            cls = mf[bge_pkg::F_PASS_DIGIT];
                            take_ok = bge_pkg::is_digit(i_st.ch);
                            take_pass = 1'b1;
                        end
                        bge_pkg::CH_LD: begin
                            cls = mf[bge_pkg::F_SKIP_DIGIT];
                            take_ok = bge_pkg::is_digit(i_st.ch);
                        end
                        bge_pkg::CH_UL: begin
                            cls = mf[bge_pkg::F_PASS_LOWER] || mf[bge_pkg::F_PASS_UPPER];
                            take_ok = (mf[bge_pkg::F_PASS_LOWER] && bge_pkg::is_lower(i_st.ch))
                                || (mf[bge_pkg::F_PASS_UPPER] && bge_pkg::is_upper(i_st.ch));
                            take_pass = 1'b1;
                        end
                        bge_pkg::CH_LL: begin
                            cls = mf[bge_pkg::F_SKIP_LOWER] || mf[bge_pkg::F_SKIP_UPPER];
                            take_ok = (mf[bge_pkg::F_SKIP_LOWER] && bge_pkg::is_lower(i_st.ch))
                                || (mf[bge_pkg::F_SKIP_UPPER] && bge_pkg::is_upper(i_st.ch));
                        end
                        bge_pkg::CH_SQUOT: begin
                            if (i_st.c2 != bge_pkg::CH_SQUOT) begin
                                done = 1'b1;
                                dst  = bge_pkg::ST_MALFORMED;
                            end else if (i_st.ch == i_st.c1) begin
                                o_dp.ip_op = bge_pkg::CNT_INC;
                                o_dp.gp_op = bge_pkg::GP_INC3;
                            end else begin
                                n_mode     = bge_pkg::MODE_BACK;
                                o_dp.gp_op = bge_pkg::GP_DEC1;
                            end
                        end
                        bge_pkg::CH_DQUOT: begin
                            if (i_st.c2 != bge_pkg::CH_DQUOT) begin
                                done = 1'b1;
                                dst  = bge_pkg::ST_MALFORMED;
                            end else if (i_st.ol_full) begin
                                done = 1'b1;
                                dst  = bge_pkg::ST_OUT_LONG;
                            end else begin
                                o_dp.emit     = 1'b1;
                                o_dp.emit_lit = 1'b1;
                                o_dp.ol_op    = bge_pkg::CNT_INC;
                                o_dp.gp_op    = bge_pkg::GP_INC3;
                            end
                        end
                        bge_pkg::CH_SPACE, bge_pkg::CH_NL: begin
                            o_dp.gp_op = bge_pkg::GP_INC1;
                        end
                        bge_pkg::CH_SEMI: begin
                            if (i_st.nc_zero) begin
                                done = 1'b1;
                                dst  = bge_pkg::ST_OK;
                            end else if (i_st.nu_full) begin
                                done = 1'b1;
                                dst  = bge_pkg::ST_UNDO_OVF;
                            end else begin
                                o_dp.nu_op = bge_pkg::STK_PUSH;
                                o_dp.nc_op = bge_pkg::STK_POP;
                                o_dp.gp_op = bge_pkg::GP_TOP_P1;
                            end
                        end
                        default: begin
                            if (bge_pkg::is_lower(c) || bge_pkg::is_upper(c)) begin
                                do_call = 1'b1;
                            end else begin
                                done = 1'b1;
                                dst  = bge_pkg::ST_MALFORMED;
                            end
                        end
                    endcase
                    // Builtin classes are rule names when disabled
                    if (c == bge_pkg::CH_UA || c == bge_pkg::CH_LA || c == bge_pkg::CH_UD
                        || c == bge_pkg::CH_LD || c == bge_pkg::CH_UL
                        || c == bge_pkg::CH_LL) begin
                        take_en = cls;
                        do_call = !cls;
                    end
                    if (take_en) begin
                        if (!take_ok) begin
                            n_mode     = bge_pkg::MODE_BACK;
                            o_dp.gp_op = bge_pkg::GP_DEC1;
                        end else if (take_pass && i_st.ol_full) begin
                            done = 1'b1;
                            dst  = bge_pkg::ST_OUT_LONG;
                        end else begin
                            o_dp.emit  = take_pass;
                            o_dp.ol_op = take_pass ? bge_pkg::CNT_INC : bge_pkg::CNT_HOLD;
                            o_dp.ip_op = bge_pkg::CNT_INC;
                            o_dp.gp_op = bge_pkg::GP_INC1;
                        end
                    end
                    if (do_call) begin
                        if (i_st.nc_full) begin
                            done = 1'b1;
                            dst  = bge_pkg::ST_CALL_OVF;
                        end else begin
                            o_dp.nc_op = bge_pkg::STK_PUSH;
                            o_dp.gp_op = bge_pkg::GP_PREFIX;
                            n_mode     = bge_pkg::MODE_SEARCH;
                        end
                    end
                end else if (r_mode == bge_pkg::MODE_BACK) begin
                    priority case (c)
                        bge_pkg::CH_UA: begin
                            cls = 1'b1;
                            cls_on = mf[bge_pkg::F_PASS_ANY];
                            take_pass = 1'b1;
                        end
                        bge_pkg::CH_UL: begin
                            cls = 1'b1;
                            cls_on = mf[bge_pkg::F_PASS_LOWER] || mf[bge_pkg::F_PASS_UPPER];
                            take_pass = 1'b1;
                        end
                        bge_pkg::CH_UD: begin
                            cls = 1'b1;
                            cls_on = mf[bge_pkg::F_PASS_DIGIT];
                            take_pass = 1'b1;
                        end
                        bge_pkg::CH_LA: begin
                            cls = 1'b1;
                            cls_on = mf[bge_pkg::F_SKIP_ANY];
                        end
                        bge_pkg::CH_LL: begin
                            cls = 1'b1;
                            cls_on = mf[bge_pkg::F_SKIP_LOWER] || mf[bge_pkg::F_SKIP_UPPER];
                        end
                        bge_pkg::CH_LD: begin
                            cls = 1'b1;
                            cls_on = mf[bge_pkg::F_SKIP_DIGIT];
                        end
                        bge_pkg::CH_SQUOT: begin
                            o_dp.ip_op = bge_pkg::CNT_DEC;
                            o_dp.gp_op = bge_pkg::GP_DEC3;
                        end
                        bge_pkg::CH_DQUOT: begin
                            o_dp.ol_op = i_st.ol_nz ? bge_pkg::CNT_DEC : bge_pkg::CNT_HOLD;
                            o_dp.gp_op = bge_pkg::GP_DEC3;
                        end
                        bge_pkg::CH_SPACE, bge_pkg::CH_NL: begin
                            o_dp.gp_op = bge_pkg::GP_DEC1;
                        end
                        bge_pkg::CH_EQ: begin
                            n_mode     = bge_pkg::MODE_SEARCH;
                            o_dp.gp_op = bge_pkg::GP_INC1;
                        end
                        default: begin
                            if (bge_pkg::is_lower(c) || bge_pkg::is_upper(c)) begin
                                do_uncall = 1'b1;
                            end else begin
                                done = 1'b1;
                                dst  = bge_pkg::ST_MALFORMED;
                            end
                        end
                    endcase
                    // Undo a class match, or retry the rule call it stood for
                    if (cls) begin
                        if (cls_on) begin
                            if (take_pass && i_st.ol_nz) begin
                                o_dp.ol_op = bge_pkg::CNT_DEC;
                            end
                            o_dp.ip_op = bge_pkg::CNT_DEC;
                            o_dp.gp_op = bge_pkg::GP_DEC1;
                        end else begin
                            do_uncall = 1'b1;
                        end
                    end
                    if (do_uncall) begin
                        if (i_st.nc_full) begin
                            done = 1'b1;
                            dst  = bge_pkg::ST_CALL_OVF;
                        end else if (i_st.nu_zero) begin
                            done = 1'b1;
                            dst  = bge_pkg::ST_MALFORMED;
                        end else begin
                            o_dp.nc_op = bge_pkg::STK_PUSH;
                            o_dp.nu_op = bge_pkg::STK_POP;
                            o_dp.gp_op = bge_pkg::GP_UTOP;
                        end
                    end
                end else begin
                    // Search: skip right sides up to the next semicolon
                    if (bge_pkg::is_lower(c) || bge_pkg::is_upper(c)
                        || bge_pkg::is_blank(c)) begin
                        o_dp.gp_op = bge_pkg::GP_INC1;
                    end else if (c == bge_pkg::CH_SQUOT || c == bge_pkg::CH_DQUOT) begin
                        if (i_st.c2 != c) begin
                            done = 1'b1;
                            dst  = bge_pkg::ST_MALFORMED;
                        end else begin
                            o_dp.gp_op = bge_pkg::GP_INC3;
                        end
                    end else if (c != bge_pkg::CH_SEMI) begin
                        done = 1'b1;
                        dst  = bge_pkg::ST_MALFORMED;
                    end else begin
                        o_dp.gp_op = bge_pkg::GP_INC1;
                        n_ret      = S_SA;
                        n_state    = S_DB0;
                    end
                end
            end

            // Rule head reached: end of grammar, or read the wanted name
            S_SA: begin
                if (i_st.gp_end) begin
                    if (i_st.nc_le1) begin
                        done = 1'b1;
                        dst  = bge_pkg::ST_UNPARSABLE;
                    end else begin
                        o_dp.gp_op = bge_pkg::GP_TOP_M1;
                        o_dp.nc_op = bge_pkg::STK_POP;
                        n_mode     = bge_pkg::MODE_BACK;
                        n_state    = S_F0;
                    end
                end else begin
                    o_dp.gsel = bge_pkg::GS_TOP;
                    n_state   = S_SB;
                end
            end

            // Compare the head with the pending call
            S_SB: begin
                if (!i_st.nc_zero && (i_st.gdat == c)) begin
                    n_mode = bge_pkg::MODE_PARSE;
                end
                o_dp.gp_op = bge_pkg::GP_INC1;
                n_ret      = S_SE;
                n_state    = S_DB0;
            end

            // Expect the equals sign after the head
            S_SE: begin
                if (c != bge_pkg::CH_EQ) begin
                    done = 1'b1;
                    dst  = bge_pkg::ST_MALFORMED;
                end else begin
                    o_dp.gp_op = bge_pkg::GP_INC1;
                    n_state    = S_F0;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // End the run with its status
        if (done) begin
            n_run_st = dst;
            n_state  = S_FIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_F0;
            r_mode    <= bge_pkg::MODE_SEARCH;
            r_kind    <= bge_pkg::CMD_WR_GRAMMAR;
            r_run_st  <= bge_pkg::ST_OK;
            r_last_st <= bge_pkg::ST_OK;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_mode    <= n_mode;
            r_kind    <= n_kind;
            r_run_st  <= n_run_st;
            r_last_st <= n_last_st;
            r_ovalid  <= n_ovalid;
        end
    end

    assign o_m_valid = r_ovalid;
    assign o_status  = r_last_st;

endmodule

// File: rtl/core/backtracking_grammar_executor.sv
// Top level of the backtracking grammar executor.
//
//  channel  direction  handshake                  payload
//  s_axis   in         i_s_tvalid / o_s_tready    i_s_tdata: cmd, index, byte_in
//  m_axis   out        o_m_tvalid / i_m_tready    o_m_tdata: status, out_length, byte_out
//  cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Loads and output reads pass through the FIN state from transfer to result.
// A run passes through states F0 to F3 and EX per interpreter step, plus DB0
// and DB1 per blank skipped; the single read port of the grammar RAM sets this.
// Reset is synchronous and active low; the memories keep their contents.
// No new command is taken until the previous result has been transferred.
module backtracking_grammar_executor #(
    parameter int MEM_DEPTH  = 4096,
    parameter int CALL_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // cmd[1:0], index[13:2], byte_in[21:14], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // status[2:0], out_length[15:3], byte_out[23:16]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    bge_pkg::t_dp_cmd  dp_cmd;
    bge_pkg::t_dp_stat dp_stat;
    logic [2:0]  status;
    logic [12:0] out_length;
    logic [7:0]  byte_out;

    assign o_cfg_ready = 1'b1;

    bge_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_cmd     (i_s_tdata[1:0]),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_status  (status),
        .i_st      (dp_stat),
        .o_dp      (dp_cmd)
    );

    bge_dp #(
        .MEM_DEPTH  (MEM_DEPTH),
        .CALL_DEPTH (CALL_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_index      (i_s_tdata[13:2]),
        .i_byte       (i_s_tdata[21:14]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_length (out_length),
        .o_byte_out   (byte_out)
    );

    assign o_m_tdata = {byte_out, out_length, status};

endmodule
